// ----- hdl/triangle_rasterizer_zbuffer_core_assert.svh -----
// Assertion macros for the triangle rasterizer checker.
// Sampled on the rising edge of clk and held off during rst.
`ifndef TRIANGLE_RASTERIZER_ZBUFFER_CORE_ASSERT_SVH
`define TRIANGLE_RASTERIZER_ZBUFFER_CORE_ASSERT_SVH

// Same-cycle implication.
`define TRZB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trzb assertion failed");

// Next-cycle implication.
`define TRZB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trzb assertion failed");

`endif

// ----- hdl/trzb_pkg.sv -----
// Types, codes and helpers for the triangle rasterizer with depth buffer.
// No dependencies.
package trzb_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SETUP, ST_PIX, ST_MUL, ST_DIV, ST_WRITE,
    ST_RD_ADDR, ST_RD_MEM, ST_RD_OUT
  } state_t;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] CFG_RED   = 2'd0;
  localparam logic [1:0] CFG_GREEN = 2'd1;
  localparam logic [1:0] CFG_BLUE  = 2'd2;

  localparam logic [7:0] RED_GAIN_RST   = 8'd155;
  localparam logic [7:0] GREEN_GAIN_RST = 8'd0;
  localparam logic [7:0] BLUE_GAIN_RST  = 8'd0;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  function automatic logic [7:0] chan_scale(input logic [7:0] gain, input logic [8:0] light);
    logic [16:0] p;
    begin
      p = 17'(gain) * 17'(light);
      chan_scale = p[16] ? 8'hFF : p[15:8];
    end
  endfunction

  function automatic logic signed [11:0] min3s(input logic signed [11:0] a,
                                               input logic signed [11:0] b,
                                               input logic signed [11:0] c);
    logic signed [11:0] m;
    begin
      m = (a < b) ? a : b;
      min3s = (m < c) ? m : c;
    end
  endfunction

  function automatic logic signed [11:0] max3s(input logic signed [11:0] a,
                                               input logic signed [11:0] b,
                                               input logic signed [11:0] c);
    logic signed [11:0] m;
    begin
      m = (a > b) ? a : b;
      max3s = (m > c) ? m : c;
    end
  endfunction

  function automatic logic signed [45:0] times_10000(input logic signed [29:0] w);
    logic signed [45:0] e;
    begin
      e = {{16{w[29]}}, w};
      times_10000 = (e <<< 13) + (e <<< 10) + (e <<< 9) + (e <<< 8) + (e <<< 4);
    end
  endfunction

endpackage

// ----- hdl/triangle_rasterizer_zbuffer_core.sv -----
// Triangle rasterizer with depth and color stores in single-port synchronous memories.
// Clear zeroes both stores; read fetches (ax, ay). Draw runs a setup pass, then scans
// the clipped box one pixel per cycle, holding at covered pixels for a 16-step divide.
// Reset runs a clearing pass of all W*H pixels with busy high and no result; gains take reset values.
// done marks each result for one cycle; the next command may start in that cycle.
module triangle_rasterizer_zbuffer_core #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [11:0] ax,
  input  logic signed [11:0] ay,
  input  logic signed [11:0] bx,
  input  logic signed [11:0] by,
  input  logic signed [11:0] cx,
  input  logic signed [11:0] cy,
  input  logic [15:0]        inv_depth_a,
  input  logic [15:0]        inv_depth_b,
  input  logic [15:0]        inv_depth_c,
  input  logic [8:0]         light_level,
  output logic               done,
  output logic               back_facing,
  output logic [16:0]        pixels_written,
  output logic [23:0]        read_color,
  output logic [15:0]        read_depth,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NPIX - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_WIDTH);
  localparam logic signed [11:0] XMAX = 12'(SCREEN_WIDTH - 1);
  localparam logic signed [11:0] YMAX = 12'(SCREEN_HEIGHT - 1);
  localparam logic signed [16:0] WMUL = 17'(SCREEN_WIDTH);

  trzb_pkg::state_t state, state_next;

  logic [7:0] red_gain, green_gain, blue_gain;

  logic signed [11:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
  logic [15:0] r_da, r_db, r_dc;
  logic [8:0]  r_light;

  logic signed [11:0] x0, x1, y0, y1, x, y;
  logic [23:0] color;
  logic signed [29:0] area, wa, wb, wa_row, wb_row, wc;
  logic signed [29:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [46:0] prod;
  logic signed [49:0] prodx, acc, area_hi;
  logic [26:0] rem;
  logic [15:0] dq;
  logic [27:0] dtrial, dsub;
  logic dge;
  logic [2:0] stp;
  logic [1:0] mc;
  logic [4:0] dcnt;
  logic [16:0] count, cnt_new;
  logic [AW-1:0] addr, row_addr, rd_addr;
  logic clr_quiet, rd_ok, covered, at_end, hit, adv, we, rd_en, in_range;
  logic signed [45:0] neg_area;

  logic [15:0] depth_mem [NPIX];
  logic [23:0] color_mem [NPIX];
  logic [15:0] depth_q;
  logic [23:0] color_q;

  logic signed [12:0] ax13, ay13, bx13, by13, cx13, cy13, x013, y013;
  logic signed [12:0] d_acx, d_bcy, d_acy, d_bcx, d_cay, d_cax;
  logic signed [12:0] s_x0c, s_y0c, s_x0a, s_y0a;
  logic signed [11:0] lo_x, hi_x, lo_y, hi_y;

  assign ax13 = {r_ax[11], r_ax};
  assign ay13 = {r_ay[11], r_ay};
  assign bx13 = {r_bx[11], r_bx};
  assign by13 = {r_by[11], r_by};
  assign cx13 = {r_cx[11], r_cx};
  assign cy13 = {r_cy[11], r_cy};
  assign x013 = {x0[11], x0};
  assign y013 = {y0[11], y0};
  assign d_acx = ax13 - cx13;
  assign d_acy = ay13 - cy13;
  assign d_bcy = by13 - cy13;
  assign d_bcx = bx13 - cx13;
  assign d_cay = cy13 - ay13;
  assign d_cax = cx13 - ax13;
  assign s_x0c = x013 - cx13;
  assign s_y0c = y013 - cy13;
  assign s_x0a = x013 - ax13;
  assign s_y0a = y013 - ay13;

  assign lo_x = trzb_pkg::min3s(r_ax, r_bx, r_cx);
  assign hi_x = trzb_pkg::max3s(r_ax, r_bx, r_cx);
  assign lo_y = trzb_pkg::min3s(r_ay, r_by, r_cy);
  assign hi_y = trzb_pkg::max3s(r_ay, r_by, r_cy);

  assign cfg_ready = 1'b1;
  assign busy = (state != trzb_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_gain   <= trzb_pkg::RED_GAIN_RST;
      green_gain <= trzb_pkg::GREEN_GAIN_RST;
      blue_gain  <= trzb_pkg::BLUE_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        trzb_pkg::CFG_RED:   red_gain   <= cfg_data;
        trzb_pkg::CFG_GREEN: green_gain <= cfg_data;
        trzb_pkg::CFG_BLUE:  blue_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      trzb_pkg::ST_SETUP: begin
        unique case (stp)
          3'd0: begin mul_a = 30'(d_acx); mul_b = 17'(d_bcy); end
          3'd1: begin mul_a = 30'(d_acy); mul_b = 17'(d_bcx); end
          3'd2: begin mul_a = 30'(s_x0c); mul_b = 17'(d_bcy); end
          3'd3: begin mul_a = 30'(s_y0c); mul_b = 17'(d_bcx); end
          3'd4: begin mul_a = 30'(s_x0a); mul_b = 17'(d_cay); end
          3'd5: begin mul_a = 30'(s_y0a); mul_b = 17'(d_cax); end
          3'd6: begin mul_a = 30'(y013);  mul_b = WMUL; end
          default: ;
        endcase
      end
      trzb_pkg::ST_MUL: begin
        unique case (mc)
          2'd0: begin mul_a = wa; mul_b = {1'b0, r_da}; end
          2'd1: begin mul_a = wb; mul_b = {1'b0, r_db}; end
          2'd2: begin mul_a = wc; mul_b = {1'b0, r_dc}; end
          default: ;
        endcase
      end
      trzb_pkg::ST_RD_ADDR: begin mul_a = 30'(ay13); mul_b = WMUL; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign prodx    = {{3{prod[46]}}, prod};
  assign wc       = area - wa - wb;
  assign neg_area = -{{16{area[29]}}, area};
  assign covered  = (trzb_pkg::times_10000(wa) >= neg_area) &&
                    (trzb_pkg::times_10000(wb) >= neg_area) &&
                    (trzb_pkg::times_10000(wc) >= neg_area);
  assign at_end   = (x == x1) && (y == y1);
  assign area_hi  = {{4{area[29]}}, area, 16'b0};
  assign dtrial   = {rem, dq[15]};
  assign dsub     = dtrial - {1'b0, area[26:0]};
  assign dge      = (dtrial >= {1'b0, area[26:0]});
  assign hit      = (state == trzb_pkg::ST_WRITE) && (dq >= depth_q);
  assign cnt_new  = (hit && count != trzb_pkg::COUNT_MAX) ? count + 17'd1 : count;
  assign adv      = ((state == trzb_pkg::ST_PIX) && !covered) || (state == trzb_pkg::ST_WRITE);
  assign in_range = (r_ax >= 0) && (r_ax <= XMAX) && (r_ay >= 0) && (r_ay <= YMAX);

  always_comb begin
    state_next = state;
    unique case (state)
      trzb_pkg::ST_IDLE: begin
        if (start) begin
          unique case (cmd)
            trzb_pkg::CMD_CLEAR: state_next = trzb_pkg::ST_CLEAR;
            trzb_pkg::CMD_DRAW:  state_next = trzb_pkg::ST_SETUP;
            trzb_pkg::CMD_READ:  state_next = trzb_pkg::ST_RD_ADDR;
            default:             state_next = trzb_pkg::ST_RD_OUT;
          endcase
        end
      end
      trzb_pkg::ST_CLEAR: if (addr == LAST_ADDR) state_next = trzb_pkg::ST_IDLE;
      trzb_pkg::ST_SETUP: begin
        if (stp == 3'd7) begin
          if (area <= 0 || x0 > x1 || y0 > y1) state_next = trzb_pkg::ST_IDLE;
          else state_next = trzb_pkg::ST_PIX;
        end
      end
      trzb_pkg::ST_PIX: begin
        if (covered) state_next = trzb_pkg::ST_MUL;
        else if (at_end) state_next = trzb_pkg::ST_IDLE;
      end
      trzb_pkg::ST_MUL: if (mc == 2'd3) state_next = trzb_pkg::ST_DIV;
      trzb_pkg::ST_DIV: begin
        if (dcnt == 5'd0) begin
          if (acc[49] || acc >= area_hi) state_next = trzb_pkg::ST_WRITE;
        end else if (dcnt == 5'd16) begin
          state_next = trzb_pkg::ST_WRITE;
        end
      end
      trzb_pkg::ST_WRITE:   state_next = at_end ? trzb_pkg::ST_IDLE : trzb_pkg::ST_PIX;
      trzb_pkg::ST_RD_ADDR: state_next = trzb_pkg::ST_RD_MEM;
      trzb_pkg::ST_RD_MEM:  state_next = trzb_pkg::ST_RD_OUT;
      trzb_pkg::ST_RD_OUT:  state_next = trzb_pkg::ST_IDLE;
      default:              state_next = trzb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= trzb_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      addr      <= '0;
      clr_quiet <= 1'b1;
    end else begin
      done <= (state != trzb_pkg::ST_IDLE) && (state_next == trzb_pkg::ST_IDLE) &&
              !(state == trzb_pkg::ST_CLEAR && clr_quiet);
      unique case (state)
        trzb_pkg::ST_IDLE: begin
          if (start) begin
            r_ax <= ax; r_ay <= ay; r_bx <= bx; r_by <= by; r_cx <= cx; r_cy <= cy;
            r_da <= inv_depth_a; r_db <= inv_depth_b; r_dc <= inv_depth_c;
            r_light        <= light_level;
            back_facing    <= 1'b0;
            pixels_written <= '0;
            read_color     <= '0;
            read_depth     <= '0;
            stp            <= '0;
            count          <= '0;
            rd_ok          <= 1'b0;
            addr           <= '0;
            clr_quiet      <= 1'b0;
          end
        end
        trzb_pkg::ST_CLEAR: addr <= addr + 1'b1;
        trzb_pkg::ST_SETUP: begin
          stp <= stp + 3'd1;
          unique case (stp)
            3'd0: begin
              x0 <= lo_x[11] ? 12'sd0 : lo_x;
              y0 <= lo_y[11] ? 12'sd0 : lo_y;
              x1 <= (hi_x > XMAX) ? XMAX : hi_x;
              y1 <= (hi_y > YMAX) ? YMAX : hi_y;
              color <= {trzb_pkg::chan_scale(red_gain, r_light),
                        trzb_pkg::chan_scale(green_gain, r_light),
                        trzb_pkg::chan_scale(blue_gain, r_light)};
            end
            3'd1: acc <= prodx;
            3'd2: area <= 30'(acc - prodx);
            3'd3: acc <= prodx;
            3'd4: begin wa <= 30'(acc - prodx); wa_row <= 30'(acc - prodx); end
            3'd5: acc <= prodx;
            3'd6: begin wb <= 30'(acc - prodx); wb_row <= 30'(acc - prodx); end
            3'd7: begin
              addr        <= prod[AW-1:0] + AW'($unsigned(x0));
              row_addr    <= prod[AW-1:0] + AW'($unsigned(x0));
              x           <= x0;
              y           <= y0;
              back_facing <= (area <= 0);
            end
            default: ;
          endcase
        end
        trzb_pkg::ST_PIX: mc <= '0;
        trzb_pkg::ST_MUL: begin
          mc <= mc + 2'd1;
          unique case (mc)
            2'd1: acc <= prodx;
            2'd2: acc <= acc + prodx;
            2'd3: begin acc <= acc + prodx; dcnt <= '0; end
            default: ;
          endcase
        end
        trzb_pkg::ST_DIV: begin
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd0) begin
            if (acc[49]) dq <= '0;
            else if (acc >= area_hi) dq <= '1;
            else begin
              rem <= acc[42:16];
              dq  <= acc[15:0];
            end
          end else begin
            rem <= dge ? dsub[26:0] : dtrial[26:0];
            dq  <= {dq[14:0], dge};
          end
        end
        trzb_pkg::ST_WRITE: count <= cnt_new;
        trzb_pkg::ST_RD_MEM: rd_ok <= in_range;
        trzb_pkg::ST_RD_OUT: begin
          if (rd_ok) begin
            read_color <= color_q;
            read_depth <= depth_q;
          end
        end
        default: ;
      endcase
      if (adv) begin
        if (at_end) begin
          pixels_written <= cnt_new;
        end else if (x == x1) begin
          x        <= x0;
          y        <= y + 12'sd1;
          wa       <= wa_row - 30'(d_bcx);
          wa_row   <= wa_row - 30'(d_bcx);
          wb       <= wb_row - 30'(d_cax);
          wb_row   <= wb_row - 30'(d_cax);
          addr     <= row_addr + ROW_STEP;
          row_addr <= row_addr + ROW_STEP;
        end else begin
          x    <= x + 12'sd1;
          wa   <= wa + 30'(d_bcy);
          wb   <= wb + 30'(d_cay);
          addr <= addr + 1'b1;
        end
      end
    end
  end

  assign we      = (state == trzb_pkg::ST_CLEAR) || hit;
  assign rd_en   = ((state == trzb_pkg::ST_PIX) && covered) || (state == trzb_pkg::ST_RD_MEM);
  assign rd_addr = (state == trzb_pkg::ST_RD_MEM) ?
                   prod[AW-1:0] + AW'($unsigned(r_ax)) : addr;

  always_ff @(posedge clk) begin
    if (we) begin
      depth_mem[addr] <= (state == trzb_pkg::ST_WRITE) ? dq : 16'd0;
      color_mem[addr] <= (state == trzb_pkg::ST_WRITE) ? color : 24'd0;
    end
    if (rd_en) begin
      depth_q <= depth_mem[rd_addr];
      color_q <= color_mem[rd_addr];
    end
  end

endmodule

// ----- hdl/trzb_checker.sv -----
// Port-level checker for the triangle rasterizer, bound to the top level.
// Depends on triangle_rasterizer_zbuffer_core_assert.svh.
`include "triangle_rasterizer_zbuffer_core_assert.svh"

module trzb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        back_facing,
  input logic [16:0] pixels_written
);

  `TRZB_ASSERT_IMP(a_done_idle, done, !busy)
  `TRZB_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `TRZB_ASSERT_NXT(a_done_pulse, done, !done)
  `TRZB_ASSERT_IMP(a_cull_no_pixels, done && back_facing, pixels_written == 17'd0)

endmodule

bind triangle_rasterizer_zbuffer_core trzb_checker u_trzb_checker (.*);
